@@ sv/ctm_pkg.sv @@
// Package for the coaxial thrust mixer: payload types, register indexes and constants.
package ctm_pkg;

    localparam int Q_ONE = 16384;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam logic [14:0] RPY_MIX_RESET = 15'd8192;
    localparam logic [14:0] HOVER_RESET = 15'd5734;
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 17;
    localparam int DIV_QW = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPY_MIX        = 3'd0,
        CFG_HOVER_THROTTLE = 3'd1,
        CFG_ROLL_REVERSED  = 3'd2,
        CFG_PITCH_REVERSED = 3'd3,
        CFG_YAW_REVERSED   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] roll_demand;
        logic signed [15:0] pitch_demand;
        logic signed [15:0] yaw_demand;
        logic signed [15:0] throttle_demand;
        logic [14:0]        comp_gain;
        logic [14:0]        throttle_ceiling;
    } t_in;

    typedef struct packed {
        logic signed [15:0] thrust_ccw;
        logic signed [15:0] thrust_cw;
        logic signed [15:0] roll_flap;
        logic signed [15:0] pitch_flap;
        logic               hit_throttle_low;
        logic               hit_throttle_high;
        logic               hit_yaw;
        logic               hit_roll_pitch;
    } t_out;

endpackage

@@ sv/ctm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module ctm_div #(
    parameter int NW = ctm_pkg::DIV_NW,
    parameter int DW = ctm_pkg::DIV_DW,
    parameter int QW = ctm_pkg::DIV_QW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_ovf,
    output logic [QW-1:0] o_quo
);
    localparam int WW = NW + QW + 1;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= ({{(WW-NW){1'b0}}, i_num} >= ({{(WW-DW){1'b0}}, i_den} << QW));
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [WW-1:0] n_trial;
        logic [WW-1:0] n_rem_ext;
        logic          n_ge;
        assign n_trial   = {{(WW-DW){1'b0}}, r_den[k-1]} << B;
        assign n_rem_ext = {{(WW-NW){1'b0}}, r_rem[k-1]};
        assign n_ge      = n_rem_ext >= n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= r_quo[k-1] | (n_ge ? (QW'(1) << B) : '0);
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QW) begin : g_rem
            logic [WW-1:0] n_diff;
            assign n_diff = n_rem_ext - n_trial;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_ge ? n_diff[NW-1:0] : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_ovf = r_ovf[QW];
    assign o_quo = r_quo[QW];

endmodule

@@ sv/coax_thrust_mixer.sv @@
// Top level of the coaxial thrust mixer: gain scaling, throttle blend, yaw scale and flaps.
//
// Items enter on i_in with i_valid; a transfer takes place when i_valid is high
// and o_stall is low. Results leave on o_out with o_valid; a transfer takes place
// when o_valid is high and i_stall is low. Each item yields exactly one result.
// Configuration registers are written through i_cfg_valid, i_cfg_index and
// i_cfg_data; o_cfg_ready is always high. Write them only while the block is idle.
// The path from input transfer to o_valid runs through seven arithmetic stages
// and a 16-stage pipelined divider (an input register, then one quotient bit per
// stage), instantiated once each for the yaw scale and the two flap quotients.
// Throughput is one item per cycle while the receiver does not stall a waiting result.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises; nothing is lost or repeated.
module coax_thrust_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ctm_pkg::t_in                        i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ctm_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ctm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ctm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int DIV_QW = ctm_pkg::DIV_QW;
    localparam int DLY = DIV_QW + 1;

    typedef struct packed {
        logic signed [17:0] yaw;
        logic [16:0]        net;
        logic               rneg;
        logic               rzero;
        logic               pneg;
        logic               pzero;
        logic               lo;
        logic               hi;
        logic               hy;
        logic               hrp;
    } t_dly;

    logic [14:0] r_rpy_mix;
    logic [14:0] r_hover;
    logic        r_roll_rev;
    logic        r_pitch_rev;
    logic        r_yaw_rev;

    logic en;

    assign o_cfg_ready = 1'b1;
    assign en = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpy_mix   <= ctm_pkg::RPY_MIX_RESET;
            r_hover     <= ctm_pkg::HOVER_RESET;
            r_roll_rev  <= 1'b0;
            r_pitch_rev <= 1'b0;
            r_yaw_rev   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ctm_pkg::t_cfg_idx'(i_cfg_index))
                ctm_pkg::CFG_RPY_MIX:        r_rpy_mix   <= i_cfg_data;
                ctm_pkg::CFG_HOVER_THROTTLE: r_hover     <= i_cfg_data;
                ctm_pkg::CFG_ROLL_REVERSED:  r_roll_rev  <= i_cfg_data[0];
                ctm_pkg::CFG_PITCH_REVERSED: r_pitch_rev <= i_cfg_data[0];
                ctm_pkg::CFG_YAW_REVERSED:   r_yaw_rev   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [17:0] scale_dem(logic signed [15:0] d,
                                                     logic [14:0] g, logic rev);
        logic signed [31:0] p;
        logic signed [31:0] r;
        p = $signed({{16{d[15]}}, d}) * $signed({17'b0, g});
        if (rev) p = -p;
        r = (p + 32'sd8192) >>> 14;
        return r[17:0];
    endfunction

    // Stage 1: gain scaling.
    logic               r1_v;
    logic signed [17:0] r1_roll, r1_pitch, r1_yaw, r1_thr;
    logic [14:0]        r1_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_roll  <= scale_dem(i_in.roll_demand, i_in.comp_gain, r_roll_rev);
            r1_pitch <= scale_dem(i_in.pitch_demand, i_in.comp_gain, r_pitch_rev);
            r1_yaw   <= scale_dem(i_in.yaw_demand, i_in.comp_gain, r_yaw_rev);
            r1_thr   <= scale_dem(i_in.throttle_demand, i_in.comp_gain, 1'b0);
            r1_ceil  <= i_in.throttle_ceiling;
        end
    end

    // Stage 2: throttle clamp.
    logic               r2_v;
    logic signed [17:0] r2_roll, r2_pitch, r2_yaw;
    logic [14:0]        r2_thr;
    logic               r2_lo, r2_hi;
    logic               n2_lo, n2_hi;
    logic signed [17:0] n2_t;

    always_comb begin
        n2_lo = r1_thr <= 18'sd0;
        n2_t  = n2_lo ? 18'sd0 : r1_thr;
        n2_hi = n2_t >= $signed({3'b0, r1_ceil});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_roll  <= r1_roll;
            r2_pitch <= r1_pitch;
            r2_yaw   <= r1_yaw;
            r2_thr   <= n2_hi ? r1_ceil : n2_t[14:0];
            r2_lo    <= n2_lo;
            r2_hi    <= n2_hi;
        end
    end

    // Stage 3: blend products.
    logic               r3_v;
    logic signed [17:0] r3_roll, r3_pitch, r3_yaw;
    logic [14:0]        r3_thr;
    logic               r3_lo, r3_hi;
    logic [29:0]        r3_pa, r3_pb;
    logic [14:0]        n3_w;

    assign n3_w = (r_rpy_mix < 15'd16384) ? 15'(15'd16384 - r_rpy_mix) : 15'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_roll  <= r2_roll;
            r3_pitch <= r2_pitch;
            r3_yaw   <= r2_yaw;
            r3_thr   <= r2_thr;
            r3_lo    <= r2_lo;
            r3_hi    <= r2_hi;
            r3_pa    <= r2_thr * n3_w;
            r3_pb    <= r_hover * r_rpy_mix;
        end
    end

    // Stage 4: blend, best throttle and magnitudes.
    logic               r4_v;
    logic signed [17:0] r4_yaw;
    logic [14:0]        r4_thr;
    logic [13:0]        r4_best;
    logic [16:0]        r4_hh, r4_rmag, r4_pmag;
    logic [17:0]        r4_rr;
    logic               r4_rneg, r4_pneg, r4_lo, r4_hi;
    logic [31:0]        n4_sum;
    logic [17:0]        n4_blend, n4_bl2;
    logic signed [17:0] n4_ay, n4_ar, n4_ap;
    logic [16:0]        n4_mx;

    always_comb begin
        n4_sum   = 32'(r3_pa) + 32'(r3_pb) + 32'd8192;
        n4_blend = n4_sum[31:14];
        n4_bl2   = (n4_blend < {3'b0, r3_thr}) ? {3'b0, r3_thr} : n4_blend;
        n4_ay    = r3_yaw[17] ? -r3_yaw : r3_yaw;
        n4_ar    = r3_roll[17] ? -r3_roll : r3_roll;
        n4_ap    = r3_pitch[17] ? -r3_pitch : r3_pitch;
        n4_mx    = (n4_ar > n4_ap) ? n4_ar[16:0] : n4_ap[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_yaw  <= r3_yaw;
            r4_thr  <= r3_thr;
            r4_best <= (n4_bl2 < 18'd8192) ? n4_bl2[13:0] : 14'd8192;
            r4_hh   <= n4_ay[16:0];
            r4_rmag <= n4_ar[16:0];
            r4_pmag <= n4_ap[16:0];
            r4_rneg <= r3_roll[17];
            r4_pneg <= r3_pitch[17];
            r4_rr   <= {n4_mx, 1'b0};
            r4_lo   <= r3_lo;
            r4_hi   <= r3_hi;
        end
    end

    // Stage 5: throttle adjustment and net thrust.
    logic               r5_v;
    logic signed [17:0] r5_yaw;
    logic [13:0]        r5_best;
    logic [16:0]        r5_hh, r5_rmag, r5_pmag, r5_net;
    logic               r5_rneg, r5_pneg, r5_lo, r5_hi, r5_hy, r5_hrp;
    logic signed [19:0] n5_tt, n5_bb, n5_hh, n5_rr, n5_adj, n5_fa, n5_ua, n5_net;
    logic               n5_lo, n5_hi, n5_hy, n5_hrp;

    always_comb begin
        n5_tt  = $signed({4'b0, r4_thr, 1'b0});
        n5_bb  = $signed({5'b0, r4_best, 1'b0});
        n5_hh  = $signed({3'b0, r4_hh});
        n5_rr  = $signed({2'b0, r4_rr});
        n5_adj = n5_tt - n5_bb;
        n5_fa  = ((n5_hh < n5_rr) ? n5_hh : n5_rr) - n5_bb;
        n5_ua  = 20'sd32768 - (n5_bb + n5_hh);
        n5_lo  = r4_lo;
        n5_hi  = r4_hi;
        n5_hy  = 1'b0;
        n5_hrp = 1'b0;
        if (n5_bb < n5_hh) begin
            n5_hy = 1'b1;
            if (n5_adj < 0) n5_lo = 1'b1;
            else if (n5_adj > 0) n5_hi = 1'b1;
            n5_adj = '0;
        end else if (n5_adj < n5_fa) begin
            n5_adj = n5_fa;
            n5_lo  = 1'b1;
            if (n5_rr > n5_bb + n5_fa) n5_hrp = 1'b1;
        end else if (n5_adj > n5_ua) begin
            n5_adj = n5_ua;
            n5_hi  = 1'b1;
        end
        n5_net = n5_bb + n5_adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_yaw  <= r4_yaw;
            r5_best <= r4_best;
            r5_hh   <= r4_hh;
            r5_rmag <= r4_rmag;
            r5_pmag <= r4_pmag;
            r5_rneg <= r4_rneg;
            r5_pneg <= r4_pneg;
            r5_net  <= n5_net[16:0];
            r5_lo   <= n5_lo;
            r5_hi   <= n5_hi;
            r5_hy   <= n5_hy;
            r5_hrp  <= n5_hrp;
        end
    end

    // Divisions: yaw scale and the two flap quotients.
    logic                yd_ovf, rd_ovf, pd_ovf;
    logic [DIV_QW-1:0]   yd_q, rd_q, pd_q;

    ctm_div #(.NW(ctm_pkg::DIV_NW), .DW(ctm_pkg::DIV_DW), .QW(DIV_QW)) u_div_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({3'b0, r5_best, 15'b0}),
        .i_den (r5_hh),
        .o_ovf (yd_ovf),
        .o_quo (yd_q)
    );

    ctm_div #(.NW(ctm_pkg::DIV_NW), .DW(ctm_pkg::DIV_DW), .QW(DIV_QW)) u_div_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r5_rmag, 15'b0}),
        .i_den (r5_net),
        .o_ovf (rd_ovf),
        .o_quo (rd_q)
    );

    ctm_div #(.NW(ctm_pkg::DIV_NW), .DW(ctm_pkg::DIV_DW), .QW(DIV_QW)) u_div_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r5_pmag, 15'b0}),
        .i_den (r5_net),
        .o_ovf (pd_ovf),
        .o_quo (pd_q)
    );

    t_dly r_dly [DLY];
    logic r_dv  [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) r_dv[i] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r5_v;
            for (int i = 1; i < DLY; i++) r_dv[i] <= r_dv[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= '{yaw: r5_yaw, net: r5_net, rneg: r5_rneg, rzero: (r5_rmag == '0),
                          pneg: r5_pneg, pzero: (r5_pmag == '0), lo: r5_lo, hi: r5_hi,
                          hy: r5_hy, hrp: r5_hrp || (r5_net == '0)};
            for (int i = 1; i < DLY; i++) r_dly[i] <= r_dly[i-1];
        end
    end

    // Stage 6: yaw product and flap limits.
    logic               r6_v;
    logic signed [33:0] r6_prod;
    logic [16:0]        r6_net;
    logic signed [15:0] r6_rf, r6_pf;
    logic               r6_lo, r6_hi, r6_hy, r6_hrp;
    logic [14:0]        n6_ys;
    logic               n6_rhit, n6_phit;
    logic [14:0]        n6_rmag, n6_pmag;
    t_dly               n6_d;

    always_comb begin
        n6_d    = r_dly[DLY-1];
        n6_ys   = (yd_ovf || yd_q > 15'd16384) ? 15'd16384 : yd_q;
        n6_rhit = (rd_ovf || rd_q > 15'd16384) && !n6_d.rzero;
        n6_phit = (pd_ovf || pd_q > 15'd16384) && !n6_d.pzero;
        n6_rmag = n6_d.rzero ? 15'd0 : (n6_rhit ? 15'd16384 : rd_q);
        n6_pmag = n6_d.pzero ? 15'd0 : (n6_phit ? 15'd16384 : pd_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r_dv[DLY-1];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_prod <= $signed({1'b0, n6_ys}) * n6_d.yaw;
            r6_net  <= n6_d.net;
            r6_rf   <= n6_d.rneg ? -$signed({1'b0, n6_rmag}) : $signed({1'b0, n6_rmag});
            r6_pf   <= n6_d.pneg ? -$signed({1'b0, n6_pmag}) : $signed({1'b0, n6_pmag});
            r6_lo   <= n6_d.lo;
            r6_hi   <= n6_d.hi;
            r6_hy   <= n6_d.hy;
            r6_hrp  <= n6_d.hrp || n6_rhit || n6_phit;
        end
    end

    // Stage 7: rotor thrusts and output register.
    logic               r7_v;
    ctm_pkg::t_out      r7_out;
    logic signed [35:0] n7_nq, n7_p, n7_ccw, n7_cw;

    function automatic logic signed [15:0] sat16(logic signed [35:0] v);
        if (v > 36'sd32767) return 16'sh7FFF;
        if (v < -36'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    always_comb begin
        n7_nq  = $signed({5'b0, r6_net, 14'b0});
        n7_p   = $signed({{2{r6_prod[33]}}, r6_prod});
        n7_ccw = (n7_nq + n7_p + 36'sd16384) >>> 15;
        n7_cw  = (n7_nq - n7_p + 36'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_out.thrust_ccw        <= sat16(n7_ccw);
            r7_out.thrust_cw         <= sat16(n7_cw);
            r7_out.roll_flap         <= r6_rf;
            r7_out.pitch_flap        <= r6_pf;
            r7_out.hit_throttle_low  <= r6_lo;
            r7_out.hit_throttle_high <= r6_hi;
            r7_out.hit_yaw           <= r6_hy;
            r7_out.hit_roll_pitch    <= r6_hrp;
        end
    end

    assign o_valid = r7_v;
    assign o_out   = r7_out;

endmodule
